### src/tbrp_pkg.sv
// tbrp_pkg: shared types and constants for the token bucket read pacer.
// Command and status codes, register indexes, controller states, control structs.
// No dependencies.
`default_nettype none

package tbrp_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned TIME_W = 64;

  // input item commands
  typedef enum logic [1:0] {
    CMD_READ     = 2'd0,
    CMD_CONSUMED = 2'd1,
    CMD_RESET    = 2'd2,
    CMD_CLOSE    = 2'd3
  } tbrp_cmd_code_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_GRANTED   = 2'd0,
    STAT_POSTPONED = 2'd1,
    STAT_CLOSED    = 2'd2,
    STAT_ACK       = 2'd3
  } tbrp_status_t;

  // configuration register indexes
  localparam logic [1:0] REG_BYTE_RATE   = 2'd0;
  localparam logic [1:0] REG_BURST_FLOOR = 2'd1;
  localparam logic [1:0] REG_BURST_CAP   = 2'd2;

  localparam logic [DATA_W-1:0] BYTE_RATE_RST   = 32'h0100_0000;
  localparam logic [DATA_W-1:0] BURST_FLOOR_RST = 32'd1;
  localparam logic [DATA_W-1:0] BURST_CAP_RST   = 32'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_UPDATE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } tbrp_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic simple;    // non-read command, or any command while closed
    logic mul_lo;    // low half of elapsed time times rate
    logic mul_hi;    // high half
    logic sum;       // combine partial products
    logic update;    // top up quota, restamp time
    logic check;     // grant or start wait division
    logic div_step;  // one quotient bit
    logic emit;      // move result into output register
  } tbrp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic run_read;  // open and command is a read
    logic need_div;  // quota short and rate nonzero
    logic div_last;  // final quotient bit this cycle
  } tbrp_sts_t;

endpackage

`default_nettype wire

### src/tbrp_if.sv
// tbrp_if: valid/ready channel interfaces for request items and result items.
// Depends on tbrp_pkg for field widths.
`default_nettype none

interface tbrp_in_if import tbrp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [TIME_W-1:0] now_ns;
  logic [DATA_W-1:0] want_bytes;
  logic [DATA_W-1:0] used_bytes;

  modport source (output valid, cmd, now_ns, want_bytes, used_bytes, input ready);
  modport sink   (input valid, cmd, now_ns, want_bytes, used_bytes, output ready);
endinterface

interface tbrp_out_if import tbrp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [DATA_W-1:0] grant_bytes;
  logic [TIME_W-1:0] retry_delay_ns;

  modport source (output valid, status, grant_bytes, retry_delay_ns, input ready);
  modport sink   (input valid, status, grant_bytes, retry_delay_ns, output ready);
endinterface

`default_nettype wire

### src/tbrp_datapath.sv
// tbrp_datapath: config registers, quota state, shared 32x32 multiplier,
// restoring divider and result/output registers. Depends on tbrp_pkg.
`default_nettype none

module tbrp_datapath import tbrp_pkg::*; #(
  parameter int QUOTA_FRAC_BITS = 16,
  parameter int RATE_FRAC_BITS  = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [TIME_W-1:0] now_ns,
  input  wire logic [DATA_W-1:0] want_bytes,
  input  wire logic [DATA_W-1:0] used_bytes,
  input  wire tbrp_ctl_t         ctl,
  output tbrp_sts_t              sts,
  output logic [1:0]             status,
  output logic [DATA_W-1:0]      grant_bytes,
  output logic [TIME_W-1:0]      retry_delay_ns
);

  localparam int QW  = DATA_W + QUOTA_FRAC_BITS;        // quota width
  localparam int RSH = RATE_FRAC_BITS - QUOTA_FRAC_BITS;
  localparam int LSH = (RSH < 0) ? -RSH : 0;
  localparam int PW  = TIME_W + DATA_W;                 // full product
  localparam int IW  = PW + LSH;                        // top-up in quota units
  localparam int NW  = DATA_W + RATE_FRAC_BITS;         // wait numerator
  localparam int CW  = $clog2(NW + 1);

  logic [DATA_W-1:0] byte_rate, burst_floor, burst_cap;
  logic [QW-1:0]     quota_fx;
  logic [TIME_W-1:0] last_time_ns;
  logic              closed;

  logic [1:0]        item_cmd;
  logic [TIME_W-1:0] item_now, dt;
  logic [DATA_W-1:0] item_want, item_used;

  logic [TIME_W-1:0] prod_lo, prod_hi;
  logic [PW-1:0]     prod;

  logic [NW-1:0]     div_q;
  logic [DATA_W-1:0] div_rem;
  logic [CW-1:0]     div_cnt;

  logic [1:0]        res_status;
  logic [DATA_W-1:0] res_grant;
  logic [TIME_W-1:0] res_delay;

  // combinational
  logic [DATA_W-1:0] mul_a;
  logic [TIME_W-1:0] mul_p;
  logic [QW-1:0]     cap, diff, minb, shortfall, sub_used;
  logic [DATA_W-1:0] min_eff, whole;
  logic [IW-1:0]     inc;
  logic [NW-1:0]     num_init, q_next;
  logic              saturate, below;
  logic [DATA_W:0]   div_t;
  logic              div_ge;

  assign mul_a = ctl.mul_hi ? dt[TIME_W-1:DATA_W] : dt[DATA_W-1:0];
  assign mul_p = TIME_W'(mul_a) * TIME_W'(byte_rate);

  assign cap       = QW'(burst_cap) << QUOTA_FRAC_BITS;
  assign diff      = cap - quota_fx;
  assign min_eff   = (burst_floor == '0) ? DATA_W'(1) : burst_floor;
  assign minb      = QW'(min_eff) << QUOTA_FRAC_BITS;
  assign shortfall = minb - quota_fx;
  assign below     = quota_fx < minb;
  assign whole     = quota_fx[QW-1:QUOTA_FRAC_BITS];
  assign sub_used  = QW'(item_used) << QUOTA_FRAC_BITS;

  if (RSH >= 0) begin : g_rsh
    assign inc      = IW'(prod >> RSH);
    assign num_init = NW'(shortfall) << RSH;
  end else begin : g_lsh
    assign inc      = IW'(prod) << LSH;
    assign num_init = NW'(shortfall >> LSH);
  end

  assign saturate = (quota_fx >= cap) || (inc >= IW'(diff));

  assign div_t  = {div_rem, div_q[NW-1]};
  assign div_ge = div_t >= {1'b0, byte_rate};
  assign q_next = {div_q[NW-2:0], div_ge};

  assign sts.run_read = !closed && (item_cmd == CMD_READ);
  assign sts.need_div = below && (byte_rate != '0);
  assign sts.div_last = div_cnt == CW'(1);

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_rate   <= BYTE_RATE_RST;
      burst_floor <= BURST_FLOOR_RST;
      burst_cap   <= BURST_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BYTE_RATE:   byte_rate   <= cfg_data;
        REG_BURST_FLOOR: burst_floor <= cfg_data;
        REG_BURST_CAP:   burst_cap   <= cfg_data;
        default: ;
      endcase
    end
  end

  // bucket state
  always_ff @(posedge clk) begin
    if (rst) begin
      quota_fx     <= '0;
      last_time_ns <= '0;
      closed       <= 1'b0;
    end else if (ctl.update) begin
      quota_fx     <= saturate ? cap : quota_fx + inc[QW-1:0];
      last_time_ns <= item_now;
    end else if (ctl.simple && !closed) begin
      case (item_cmd)
        CMD_CONSUMED: quota_fx <= (quota_fx > sub_used) ? quota_fx - sub_used : '0;
        CMD_RESET: begin
          quota_fx     <= '0;
          last_time_ns <= item_now;
        end
        CMD_CLOSE: closed <= 1'b1;
        default: ;
      endcase
    end
  end

  // item capture, arithmetic, result staging
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_cmd  <= in_cmd;
      item_now  <= now_ns;
      item_want <= want_bytes;
      item_used <= used_bytes;
      dt        <= now_ns - last_time_ns;
    end
    if (ctl.mul_lo) prod_lo <= mul_p;
    if (ctl.mul_hi) prod_hi <= mul_p;
    if (ctl.sum)    prod    <= PW'(prod_lo) + {prod_hi, {DATA_W{1'b0}}};
    if (ctl.simple) begin
      res_status <= closed ? STAT_CLOSED : STAT_ACK;
      res_grant  <= '0;
      res_delay  <= '0;
    end
    if (ctl.check) begin
      div_q   <= num_init;
      div_rem <= '0;
      div_cnt <= CW'(NW);
      if (!below) begin
        res_status <= STAT_GRANTED;
        res_grant  <= (item_want < whole) ? item_want : whole;
        res_delay  <= '0;
      end else begin
        res_status <= STAT_POSTPONED;
        res_grant  <= '0;
        res_delay  <= (byte_rate == '0) ? '1 : '0;
      end
    end
    if (ctl.div_step) begin
      // remainder stays below the rate, so it fits the low DATA_W bits
      div_rem <= div_ge ? DATA_W'(div_t - {1'b0, byte_rate}) : div_t[DATA_W-1:0];
      div_q   <= q_next;
      div_cnt <= div_cnt - CW'(1);
      if (sts.div_last) res_delay <= TIME_W'(q_next);
    end
    if (ctl.emit) begin
      status         <= res_status;
      grant_bytes    <= res_grant;
      retry_delay_ns <= res_delay;
    end
  end

  a_closed_sticky: assert property (@(posedge clk) disable iff (rst) closed |=> closed)
    else $error("closed flag dropped");
  a_quota_capped: assert property (@(posedge clk) disable iff (rst)
    ctl.update |=> quota_fx <= $past(cap))
    else $error("quota above cap after top-up");
  a_grant_le_want: assert property (@(posedge clk) disable iff (rst)
    ctl.check && !below |=> res_grant <= $past(item_want))
    else $error("grant exceeds wanted bytes");

endmodule

`default_nettype wire

### src/tbrp_ctrl.sv
// tbrp_ctrl: sequencing state machine and output valid register.
// Drives tbrp_ctl_t to the datapath, reads tbrp_sts_t. Depends on tbrp_pkg.
`default_nettype none

module tbrp_ctrl import tbrp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire tbrp_sts_t sts,
  output tbrp_ctl_t      ctl
);

  tbrp_state_t state, state_next;
  logic        in_fire, slot_free;

  assign in_ready  = !rst && (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = ST_DECODE;
      ST_DECODE: state_next = sts.run_read ? ST_MUL_LO : ST_FINISH;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SUM;
      ST_SUM:    state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_CHECK;
      ST_CHECK:  state_next = sts.need_div ? ST_DIV : ST_FINISH;
      ST_DIV:    if (sts.div_last) state_next = ST_FINISH;
      ST_FINISH: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.load = in_fire;
    case (state)
      ST_DECODE: ctl.simple   = !sts.run_read;
      ST_MUL_LO: ctl.mul_lo   = 1'b1;
      ST_MUL_HI: ctl.mul_hi   = 1'b1;
      ST_SUM:    ctl.sum      = 1'b1;
      ST_UPDATE: ctl.update   = 1'b1;
      ST_CHECK:  ctl.check    = 1'b1;
      ST_DIV:    ctl.div_step = 1'b1;
      ST_FINISH: ctl.emit     = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit)      out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_DECODE)
    else $error("accepted item not decoded");
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> slot_free)
    else $error("result would overwrite an untaken one");
  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && !sts.div_last |=> state == ST_DIV)
    else $error("divider left early");

endmodule

`default_nettype wire

### src/token_bucket_read_pacer_core.sv
// token_bucket_read_pacer_core: top level of the token bucket read pacer.
// Instantiates tbrp_ctrl and tbrp_datapath; uses tbrp_pkg and tbrp_if.
//
//   port        dir   kind          contents
//   in_ch       in    valid/ready   cmd, now_ns, want_bytes, used_bytes
//   out_ch      out   valid/ready   status, grant_bytes, retry_delay_ns
//   cfg_*       in    write only    cfg_we, cfg_index, cfg_data (32b)
//
// A consumed, reset or close item, and any item while closed, passes decode and
// finish; a read passes decode, the low and high multiply, sum, update, check and
// finish. A postponed read at nonzero rate also runs the restoring divider between
// check and finish, one quotient bit per cycle, 32 + RATE_FRAC_BITS bits
// (56 by default).
// One item is in flight at a time; the next is accepted while a result waits
// in the output register. A stalled output holds the machine in its last step.
// Reset (rst, synchronous) restores register defaults, empties the quota,
// zeroes the time stamp and reopens the pacer; no item is taken during reset.
`default_nettype none

module token_bucket_read_pacer_core import tbrp_pkg::*; #(
  parameter int QUOTA_FRAC_BITS = 16,
  parameter int RATE_FRAC_BITS  = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data,
  tbrp_in_if.sink                in_ch,
  tbrp_out_if.source             out_ch
);

  tbrp_ctl_t ctl;
  tbrp_sts_t sts;

  // sequencing: one step of the read path per state, divider loops in place
  tbrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // bucket state, shared multiplier, divider and output payload register
  tbrp_datapath #(
    .QUOTA_FRAC_BITS (QUOTA_FRAC_BITS),
    .RATE_FRAC_BITS  (RATE_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (in_ch.cmd),
    .now_ns         (in_ch.now_ns),
    .want_bytes     (in_ch.want_bytes),
    .used_bytes     (in_ch.used_bytes),
    .ctl            (ctl),
    .sts            (sts),
    .status         (out_ch.status),
    .grant_bytes    (out_ch.grant_bytes),
    .retry_delay_ns (out_ch.retry_delay_ns)
  );

endmodule

`default_nettype wire

### tb/tb.sv
// tb: self-checking bench for token_bucket_read_pacer_core.
// Predicts every result from its own bucket model and compares field by field.
// Depends on tbrp_pkg, tbrp_in_if / tbrp_out_if and the core RTL.
`timescale 1ns / 1ps

module tb;
  import tbrp_pkg::*;

  localparam int QUOTA_FB = 16;
  localparam int RATE_FB  = 24;
  // Covers the slowest item, a postponed read through the divider, plus a random
  // input gap, an output stall and the register writes between phases. Plenty of margin.
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    tbrp_status_t status;
    logic [31:0]  grant;
    logic [63:0]  delay;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  tbrp_in_if  in_ch ();
  tbrp_out_if out_ch ();

  token_bucket_read_pacer_core #(
    .QUOTA_FRAC_BITS(QUOTA_FB),
    .RATE_FRAC_BITS (RATE_FB)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the registers, as last written.
  logic [31:0] sh_rate = BYTE_RATE_RST;
  logic [31:0] sh_min  = BURST_FLOOR_RST;
  logic [31:0] sh_max  = BURST_CAP_RST;

  // Bucket state: Q32.16 quota, last time stamp, closed flag.
  logic [63:0] bk_quota  = '0;
  logic [63:0] bk_stamp  = '0;
  logic        bk_closed = 1'b0;

  reply_t      reply_q[$];
  logic [63:0] wall_ns = '0;   // stimulus-side notion of current time
  bit          no_idle = 1'b0; // both sides run flat out while set
  int unsigned items_sent, replies_seen, mismatch_cnt, settings_used;
  int unsigned quiet_cycles;

  // Bucket predictor: applies one item to the shadow state, returns the reply.
  function automatic reply_t pace_reply(input tbrp_cmd_code_t c, input logic [63:0] now,
                                        input logic [31:0] want, input logic [31:0] used);
    reply_t      r;
    logic [95:0] prod;
    logic [63:0] inc, cap, floor_q, whole, sub;
    r.status = STAT_ACK;
    r.grant  = '0;
    r.delay  = '0;
    if (bk_closed) begin
      r.status = STAT_CLOSED;
    end else begin
      case (c)
        CMD_READ: begin
          cap     = {32'b0, sh_max} << QUOTA_FB;
          // a zero min burst acts as one byte
          floor_q = {32'b0, (sh_min == 32'd0) ? 32'd1 : sh_min} << QUOTA_FB;
          // exact 96-bit top-up, wrapped elapsed time, saturate above 64 bits
          prod = {32'b0, now - bk_stamp} * {64'b0, sh_rate};
          prod = prod >> (RATE_FB - QUOTA_FB);
          inc  = (|prod[95:64]) ? '1 : prod[63:0];
          if (bk_quota >= cap || inc >= cap - bk_quota) bk_quota = cap;
          else bk_quota = bk_quota + inc;
          bk_stamp = now;
          if (bk_quota < floor_q) begin
            r.status = STAT_POSTPONED;
            if (sh_rate == 32'd0) r.delay = '1;
            else r.delay = ((floor_q - bk_quota) << (RATE_FB - QUOTA_FB)) / {32'b0, sh_rate};
          end else begin
            whole    = bk_quota >> QUOTA_FB;
            r.status = STAT_GRANTED;
            r.grant  = ({32'b0, want} < whole) ? want : whole[31:0];
          end
        end
        CMD_CONSUMED: begin
          sub      = {32'b0, used} << QUOTA_FB;
          bk_quota = (bk_quota > sub) ? bk_quota - sub : '0;
        end
        CMD_RESET: begin
          bk_quota = '0;
          bk_stamp = now;
        end
        default: bk_closed = 1'b1;
      endcase
    end
    return r;
  endfunction

  // Offer one item after a random gap; predict its reply once accepted.
  task automatic send_item(input tbrp_cmd_code_t c, input logic [63:0] now,
                           input logic [31:0] want, input logic [31:0] used);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.now_ns     <= now;
    in_ch.want_bytes <= want;
    in_ch.used_bytes <= used;
    do @(posedge clk); while (!in_ch.ready);
    reply_q.push_back(pace_reply(c, now, want, used));
    items_sent++;
  endtask

  // Drop valid and wait until every reply is back and the core has gone quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BYTE_RATE:   sh_rate = val;
      REG_BURST_FLOOR: sh_min  = val;
      REG_BURST_CAP:   sh_max  = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] rate, input logic [31:0] mn, input logic [31:0] mx);
    settle();
    write_reg(REG_BYTE_RATE, rate);
    write_reg(REG_BURST_FLOOR, mn);
    write_reg(REG_BURST_CAP, mx);
    settings_used++;
  endtask

  function automatic void note_mismatch(input string what, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
    mismatch_cnt++;
    $display("%0t: %s expected 0x%0h actual 0x%0h", $realtime, what, exp_v, act_v);
  endfunction

  // Result side: random stall before each item, then compare with the oldest
  // prediction at the edge where valid and ready meet.
  initial begin : result_sink
    int unsigned stall;
    reply_t      exp_r;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      replies_seen++;
      if (reply_q.size() == 0) begin
        note_mismatch("unexpected reply, status", '0, 64'(out_ch.status));
      end else begin
        exp_r = reply_q.pop_front();
        if (out_ch.status !== exp_r.status)
          note_mismatch("status", 64'(exp_r.status), 64'(out_ch.status));
        if (out_ch.grant_bytes !== exp_r.grant)
          note_mismatch("grant_bytes", 64'(exp_r.grant), 64'(out_ch.grant_bytes));
        if (out_ch.retry_delay_ns !== exp_r.delay)
          note_mismatch("retry_delay_ns", exp_r.delay, out_ch.retry_delay_ns);
      end
    end
  end

  // Watchdog: any handshake resets the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d replies pending",
                 STALL_LIMIT, reply_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Reset defaults: zero elapsed time, normal top-up, grant clipping, over-consume,
  // wrapped time at the top of the range, time going backwards.
  task automatic test_defaults();
    send_item(CMD_READ,     64'd0,    32'd10, 32'd0);     // empty bucket: postponed
    send_item(CMD_READ,     64'd1000, 32'd0,  32'd0);     // grant of zero wanted
    send_item(CMD_READ,     64'd1000, '1,     32'd0);     // clipped to quota
    send_item(CMD_CONSUMED, 64'd0,    32'd0,  32'd300);
    send_item(CMD_CONSUMED, '1,       '1,     '1);        // more than quota: floor at zero
    send_item(CMD_READ,     64'd1000, 32'd5,  32'd0);
    send_item(CMD_RESET,    64'hFFFF_FFFF_FFFF_FFF0, 32'd0, 32'd0);
    send_item(CMD_READ,     '1,       '1,     32'd0);     // dt of 15 at the top of time
    send_item(CMD_RESET,    64'd1_000_000, 32'd0, 32'd0);
    send_item(CMD_READ,     64'd10,   '1,     '1);        // backwards: saturates at cap
    send_item(CMD_CONSUMED, 64'd0,    32'd0,  32'd0);
  endtask

  // Register extremes: zero rate, full rate, zero min, huge min, zero max, max below min.
  task automatic test_config_extremes();
    set_regs(32'd0, 32'd1, BURST_CAP_RST);
    send_item(CMD_RESET, 64'd0,   32'd0,  32'd0);
    send_item(CMD_READ,  64'd500, 32'd64, 32'd0);         // zero rate: delay all ones
    set_regs('1, 32'd0, '1);
    send_item(CMD_RESET, 64'd0, 32'd0, 32'd0);
    send_item(CMD_READ,  64'd0, 32'd7, 32'd0);            // zero min acts as one
    send_item(CMD_READ,  64'd1, '1,    32'd0);
    send_item(CMD_READ,  '1,    '1,    32'd0);            // 96-bit product saturates
    set_regs(32'd1, '1, '1);
    send_item(CMD_READ,     64'd2, '1, 32'd0);
    send_item(CMD_CONSUMED, 64'd0, 32'd0, '1);
    set_regs(32'd1, 32'd1, 32'd0);
    send_item(CMD_READ, 64'h0000_0001_0000_0000, 32'd9, 32'd0);  // cap of zero
    set_regs(32'h0100_0000, 32'd200, 32'd100);
    send_item(CMD_READ, 64'h0000_0100_0000_0000, 32'd50, 32'd0); // max below min
  endtask

  // Random traffic over several register settings. Most items are reads with time
  // stepped near the refill period of the minimum burst, so grants and postponements
  // both occur; consumed reports, quota resets, random time jumps and backward
  // steps are mixed in.
  task automatic test_random_traffic();
    logic [31:0] rate, mn, mx, mn_eff, want, used;
    logic [63:0] base, dt, now;
    int unsigned pick;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin rate = '1; mn = 32'd1 + $urandom_range(0, 1000); mx = '1; end
        1: begin rate = '0; mn = $urandom_range(1, 100); mx = $urandom_range(100, 10000); end
        2: begin rate = $urandom_range(1 << 14, 1 << 26); mn = '0; mx = $urandom_range(0, 5000); end
        3: begin rate = $urandom_range(1 << 14, 1 << 26); mn = $urandom_range(1, 500); mx = '0; end
        4: begin rate = $urandom_range(1 << 14, 1 << 28); mn = '1; mx = '1; end
        5: begin
          rate = $urandom_range(1, 1 << 10);
          mn   = $urandom_range(1, 64);
          mx   = mn + $urandom_range(0, 1000);
        end
        6: begin
          rate = $urandom_range(1 << 12, 1 << 28);
          mn   = $urandom_range(1, 4096);
          mx   = $urandom_range(0, 8192);  // sometimes below min
        end
        default: begin rate = $urandom(); mn = $urandom(); mx = $urandom(); end
      endcase
      set_regs(rate, mn, mx);
      mn_eff = (mn == 32'd0) ? 32'd1 : mn;
      // time for the bucket to refill one minimum burst, bounded
      if (rate == 32'd0) base = 64'd1000;
      else base = ({32'b0, mn_eff} << RATE_FB) / {32'b0, rate};
      if (base > 64'h10_0000_0000) base = 64'h10_0000_0000;
      if (base == 64'd0) base = 64'd1;
      send_item(CMD_RESET, wall_ns, $urandom(), $urandom());
      for (int j = 0; j < 140; j++) begin
        no_idle = ((j / 35) % 4 == 3);
        pick = $urandom_range(0, 99);
        want = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4096);
        used = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4096);
        dt   = (base * $urandom_range(0, 250)) / 100;
        if (pick < 55) begin
          wall_ns = wall_ns + dt;
          send_item(CMD_READ, wall_ns, want, $urandom());
        end else if (pick < 80) begin
          now = {$urandom(), $urandom()};    // ignored by a consumed report
          send_item(CMD_CONSUMED, now, $urandom(), used);
        end else if (pick < 88) begin
          wall_ns = wall_ns + dt;
          send_item(CMD_RESET, wall_ns, $urandom(), $urandom());
        end else if (pick < 94) begin
          wall_ns = {$urandom(), $urandom()}; // arbitrary jump
          send_item(CMD_READ, wall_ns, want, $urandom());
        end else begin
          wall_ns = wall_ns - $urandom_range(1, 1000); // clock stepped back
          send_item(CMD_READ, wall_ns, want, $urandom());
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // Close is permanent until reset, so it runs last: ack, then closed for everything.
  task automatic test_close();
    settle();
    send_item(CMD_CLOSE,    wall_ns,          32'd0, 32'd0);
    send_item(CMD_READ,     wall_ns + 64'd10, '1,    32'd0);
    send_item(CMD_CONSUMED, wall_ns,          32'd0, '1);
    send_item(CMD_RESET,    wall_ns,          32'd0, 32'd0);
    send_item(CMD_CLOSE,    wall_ns,          32'd0, 32'd0);
  endtask

  initial begin
    cfg_we           <= 1'b0;
    cfg_index        <= REG_BYTE_RATE;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_READ;
    in_ch.now_ns     <= '0;
    in_ch.want_bytes <= '0;
    in_ch.used_bytes <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_config_extremes();
    test_random_traffic();
    test_close();

    // drain, then give the core time to emit anything stray
    settle();
    repeat (80) @(posedge clk);

    $display("Summary: %0d items, %0d replies checked, %0d register settings",
             items_sent, replies_seen, settings_used);
    $display("Summary: reads, consumed reports, quota resets and close all exercised");
    if (mismatch_cnt == 0 && reply_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
src/tbrp_pkg.sv
src/tbrp_if.sv
src/tbrp_datapath.sv
src/tbrp_ctrl.sv
src/token_bucket_read_pacer_core.sv
tb/tb.sv
